@@ rtl/core/sensor_threshold_alarm_monitor_unit_defines.svh @@
// Assertion macros used by the checker file of the alarm monitor.
`ifndef SENSOR_THRESHOLD_ALARM_MONITOR_UNIT_DEFINES_SVH
`define SENSOR_THRESHOLD_ALARM_MONITOR_UNIT_DEFINES_SVH

// Checked at every clock edge outside of reset.
`define STAM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define STAM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/stam_pkg.sv @@
// Package of the alarm monitor: sizes, codes, limit defaults and lane types.
package stam_pkg;

  localparam int MAX_PROBES    = 4;
  localparam int LOAD_CHANNELS = 3;

  localparam int PROBE_FIELDS  = 4;
  localparam int LOAD_FIELDS   = 3;
  localparam int SUPPLY_FIELDS = 2;
  localparam int ENV_FIELDS    = 3;
  localparam int NUM_LANES     = 4;
  localparam int NUM_KINDS     = 4;
  localparam int KIND_W        = $clog2(NUM_KINDS);

  localparam int PROBE_LIM = (MAX_PROBES < PROBE_FIELDS) ? MAX_PROBES : PROBE_FIELDS;
  localparam int LOAD_LIM  = (LOAD_CHANNELS < LOAD_FIELDS) ? LOAD_CHANNELS : LOAD_FIELDS;

  localparam int CMD_W      = 3;
  localparam int CNT_W      = 3;
  localparam int VAL_W      = 32;
  localparam int LANE_W     = 33;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CNT_W-1:0] PROBE_LIM_C = CNT_W'(PROBE_LIM);

  localparam logic [CMD_W-1:0] CMD_PROBE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUPPLY   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ENV      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_CLR = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_PROBE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_DIFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENV_TEMP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENV_HUM   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENV_PRES  = 3'd6;

  localparam logic [15:0] S16_TOP      = 16'h7FFF;
  localparam logic [15:0] S16_BOTTOM   = 16'h8000;
  localparam logic [15:0] U16_ALL_ONES = 16'hFFFF;
  localparam logic [31:0] S32_TOP      = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_BOTTOM   = 32'h8000_0000;
  localparam logic [31:0] U32_ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [47:0] RST_PROBE_LIM  = 48'hFFFF_7FFF_8000;
  localparam logic [63:0] RST_LOAD_LIM   = 64'h7FFF_FFFF_8000_0000;
  localparam logic [31:0] RST_LOAD_DIFF  = 32'hFFFF_FFFF;
  localparam logic [47:0] RST_SUPPLY_LIM = 48'hFFFF_FFFF_0000;
  localparam logic [47:0] RST_ENV_T_LIM  = 48'hFFFF_7FFF_8000;
  localparam logic [47:0] RST_ENV_U_LIM  = 48'hFFFF_FFFF_0000;

  typedef struct packed {
    logic                     active;
    logic                     jump_en;
    logic                     inclusive;
    logic                     min_en;
    logic                     max_en;
    logic                     diff_en;
    logic signed [LANE_W-1:0] now;
    logic signed [LANE_W-1:0] prev;
    logic signed [LANE_W-1:0] min_v;
    logic signed [LANE_W-1:0] max_v;
    logic [31:0]              diff_v;
  } lane_cfg_t;

  typedef struct packed {
    logic             valid;
    logic [CMD_W-1:0] cmd;
  } stage_tag_t;

  function automatic logic signed [LANE_W-1:0] sx16(input logic [15:0] v);
    return {{(LANE_W-16){v[15]}}, v};
  endfunction

  function automatic logic signed [LANE_W-1:0] zx16(input logic [15:0] v);
    return {{(LANE_W-16){1'b0}}, v};
  endfunction

  function automatic logic signed [LANE_W-1:0] sx32(input logic [31:0] v);
    return {{(LANE_W-32){v[31]}}, v};
  endfunction

endpackage

@@ rtl/core/stam_lane.sv @@
// One compare lane: min, max and jump checks of one value, result registered.
module stam_lane
  import stam_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  lane_cfg_t cfg,
  output logic      alarm_r
);

  logic                     lo_hit;
  logic                     hi_hit;
  logic                     now_gt;
  logic signed [LANE_W-1:0] d_pos;
  logic signed [LANE_W-1:0] d_neg;
  logic [LANE_W-1:0]        jump;
  logic                     jump_hit;
  logic                     alarm_nxt;

  always_comb begin
    lo_hit   = cfg.inclusive ? (cfg.now <= cfg.min_v) : (cfg.now < cfg.min_v);
    hi_hit   = cfg.inclusive ? (cfg.now >= cfg.max_v) : (cfg.now > cfg.max_v);
    now_gt   = cfg.now > cfg.prev;
    d_pos    = cfg.now - cfg.prev;
    d_neg    = cfg.prev - cfg.now;
    jump     = now_gt ? d_pos : d_neg;
    jump_hit = cfg.jump_en && (jump > {{(LANE_W-32){1'b0}}, cfg.diff_v});
    alarm_nxt = cfg.active && ((lo_hit && cfg.min_en) || (hi_hit && cfg.max_en) ||
                               (jump_hit && cfg.diff_en));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alarm_r <= alarm_nxt;
    end
  end

endmodule

@@ rtl/core/stam_front.sv @@
// Front stage: limit registers, sample history and per-lane operand setup.
module stam_front
  import stam_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_load,
  input  logic                  s1_adv,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [CNT_W-1:0]      in_count_or_mask,
  input  logic [VAL_W-1:0]      in_value_0,
  input  logic [VAL_W-1:0]      in_value_1,
  input  logic [VAL_W-1:0]      in_value_2,
  input  logic [VAL_W-1:0]      in_value_3,
  output stage_tag_t            s1_tag,
  output lane_cfg_t             s1_lane [NUM_LANES]
);

  logic [47:0] probe_lim_r;
  logic [63:0] load_lim_r;
  logic [31:0] load_diff_r;
  logic [47:0] supply_lim_r;
  logic [47:0] env_t_lim_r;
  logic [47:0] env_h_lim_r;
  logic [47:0] env_p_lim_r;

  logic [15:0]      last_probe_r [PROBE_FIELDS];
  logic [CNT_W-1:0] last_probe_cnt_r;
  logic [31:0]      last_load_r [LOAD_FIELDS];
  logic [CNT_W-1:0] last_load_mask_r;
  logic [15:0]      last_supply_r [SUPPLY_FIELDS];
  logic [15:0]      last_env_r [ENV_FIELDS];

  logic             v1_r;
  logic             v1_nxt;
  logic [CMD_W-1:0] cmd1_r;
  lane_cfg_t        lane_r [NUM_LANES];
  lane_cfg_t        lane_nxt [NUM_LANES];

  logic [VAL_W-1:0] val [NUM_LANES];
  logic [CNT_W-1:0] probe_n;
  logic [47:0]      env_lim [ENV_FIELDS];

  assign val[0] = in_value_0;
  assign val[1] = in_value_1;
  assign val[2] = in_value_2;
  assign val[3] = in_value_3;

  assign env_lim[0] = env_t_lim_r;
  assign env_lim[1] = env_h_lim_r;
  assign env_lim[2] = env_p_lim_r;

  assign probe_n = (in_count_or_mask > PROBE_LIM_C) ? PROBE_LIM_C : in_count_or_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_lim_r  <= RST_PROBE_LIM;
      load_lim_r   <= RST_LOAD_LIM;
      load_diff_r  <= RST_LOAD_DIFF;
      supply_lim_r <= RST_SUPPLY_LIM;
      env_t_lim_r  <= RST_ENV_T_LIM;
      env_h_lim_r  <= RST_ENV_U_LIM;
      env_p_lim_r  <= RST_ENV_U_LIM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROBE:     probe_lim_r  <= cfg_data[47:0];
        REG_LOAD:      load_lim_r   <= cfg_data;
        REG_LOAD_DIFF: load_diff_r  <= cfg_data[31:0];
        REG_SUPPLY:    supply_lim_r <= cfg_data[47:0];
        REG_ENV_TEMP:  env_t_lim_r  <= cfg_data[47:0];
        REG_ENV_HUM:   env_h_lim_r  <= cfg_data[47:0];
        REG_ENV_PRES:  env_p_lim_r  <= cfg_data[47:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_nxt[i] = '0;
    end
    unique case (in_cmd)
      CMD_PROBE: begin
        for (int i = 0; i < PROBE_FIELDS; i++) begin
          lane_nxt[i].active    = CNT_W'(i) < probe_n;
          lane_nxt[i].jump_en   = CNT_W'(i) < last_probe_cnt_r;
          lane_nxt[i].inclusive = 1'b1;
          lane_nxt[i].min_en    = probe_lim_r[15:0] != S16_BOTTOM;
          lane_nxt[i].max_en    = probe_lim_r[31:16] != S16_TOP;
          lane_nxt[i].diff_en   = probe_lim_r[47:32] != U16_ALL_ONES;
          lane_nxt[i].now       = sx16(val[i][15:0]);
          lane_nxt[i].prev      = sx16(last_probe_r[i]);
          lane_nxt[i].min_v     = sx16(probe_lim_r[15:0]);
          lane_nxt[i].max_v     = sx16(probe_lim_r[31:16]);
          lane_nxt[i].diff_v    = {16'h0000, probe_lim_r[47:32]};
        end
      end
      CMD_LOAD: begin
        for (int i = 0; i < LOAD_LIM; i++) begin
          lane_nxt[i].active    = in_count_or_mask[i];
          lane_nxt[i].jump_en   = last_load_mask_r[i];
          lane_nxt[i].inclusive = 1'b1;
          lane_nxt[i].min_en    = load_lim_r[31:0] != S32_BOTTOM;
          lane_nxt[i].max_en    = load_lim_r[63:32] != S32_TOP;
          lane_nxt[i].diff_en   = load_diff_r != U32_ALL_ONES;
          lane_nxt[i].now       = sx32(val[i]);
          lane_nxt[i].prev      = sx32(last_load_r[i]);
          lane_nxt[i].min_v     = sx32(load_lim_r[31:0]);
          lane_nxt[i].max_v     = sx32(load_lim_r[63:32]);
          lane_nxt[i].diff_v    = load_diff_r;
        end
      end
      CMD_SUPPLY: begin
        for (int i = 0; i < SUPPLY_FIELDS; i++) begin
          lane_nxt[i].active    = 1'b1;
          lane_nxt[i].jump_en   = last_supply_r[i] != 16'h0000;
          lane_nxt[i].inclusive = 1'b0;
          lane_nxt[i].min_en    = supply_lim_r[15:0] != 16'h0000;
          lane_nxt[i].max_en    = supply_lim_r[31:16] != U16_ALL_ONES;
          lane_nxt[i].diff_en   = supply_lim_r[47:32] != U16_ALL_ONES;
          lane_nxt[i].now       = zx16(val[i][15:0]);
          lane_nxt[i].prev      = zx16(last_supply_r[i]);
          lane_nxt[i].min_v     = zx16(supply_lim_r[15:0]);
          lane_nxt[i].max_v     = zx16(supply_lim_r[31:16]);
          lane_nxt[i].diff_v    = {16'h0000, supply_lim_r[47:32]};
        end
      end
      CMD_ENV: begin
        for (int i = 0; i < ENV_FIELDS; i++) begin
          lane_nxt[i].active    = 1'b1;
          lane_nxt[i].jump_en   = last_env_r[i] != 16'h0000;
          lane_nxt[i].inclusive = 1'b0;
          lane_nxt[i].diff_en   = (env_lim[i][47:32] != U16_ALL_ONES) &&
                                  (env_lim[i][47:32] != 16'h0000);
          lane_nxt[i].diff_v    = {16'h0000, env_lim[i][47:32]};
          if (i == 0) begin
            lane_nxt[i].min_en = env_lim[i][15:0] != S16_BOTTOM;
            lane_nxt[i].max_en = env_lim[i][31:16] != S16_TOP;
            lane_nxt[i].now    = sx16(val[i][15:0]);
            lane_nxt[i].prev   = sx16(last_env_r[i]);
            lane_nxt[i].min_v  = sx16(env_lim[i][15:0]);
            lane_nxt[i].max_v  = sx16(env_lim[i][31:16]);
          end else begin
            lane_nxt[i].min_en = env_lim[i][15:0] != 16'h0000;
            lane_nxt[i].max_en = env_lim[i][31:16] != U16_ALL_ONES;
            lane_nxt[i].now    = zx16(val[i][15:0]);
            lane_nxt[i].prev   = zx16(last_env_r[i]);
            lane_nxt[i].min_v  = zx16(env_lim[i][15:0]);
            lane_nxt[i].max_v  = zx16(env_lim[i][31:16]);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PROBE_FIELDS; i++) begin
        last_probe_r[i] <= '0;
      end
      for (int i = 0; i < LOAD_FIELDS; i++) begin
        last_load_r[i] <= '0;
      end
      for (int i = 0; i < SUPPLY_FIELDS; i++) begin
        last_supply_r[i] <= '0;
      end
      for (int i = 0; i < ENV_FIELDS; i++) begin
        last_env_r[i] <= '0;
      end
      last_probe_cnt_r <= '0;
      last_load_mask_r <= '0;
    end else if (in_load) begin
      unique case (in_cmd)
        CMD_PROBE: begin
          for (int i = 0; i < PROBE_FIELDS; i++) begin
            last_probe_r[i] <= val[i][15:0];
          end
          last_probe_cnt_r <= probe_n;
        end
        CMD_LOAD: begin
          for (int i = 0; i < LOAD_FIELDS; i++) begin
            last_load_r[i] <= val[i];
          end
          last_load_mask_r <= in_count_or_mask;
        end
        CMD_SUPPLY: begin
          for (int i = 0; i < SUPPLY_FIELDS; i++) begin
            last_supply_r[i] <= val[i][15:0];
          end
        end
        CMD_ENV: begin
          for (int i = 0; i < ENV_FIELDS; i++) begin
            last_env_r[i] <= val[i][15:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    v1_nxt = v1_r;
    if (in_load) begin
      v1_nxt = 1'b1;
    end else if (s1_adv) begin
      v1_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      cmd1_r <= in_cmd;
      for (int i = 0; i < NUM_LANES; i++) begin
        lane_r[i] <= lane_nxt[i];
      end
    end
  end

  assign s1_tag.valid = v1_r;
  assign s1_tag.cmd   = cmd1_r;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      s1_lane[i] = lane_r[i];
    end
  end

endmodule

@@ rtl/core/stam_merge.sv @@
// Merge stage: combines lane alarms into active and sticky bits, output register.
module stam_merge
  import stam_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  stage_tag_t           s2_tag,
  input  logic [NUM_LANES-1:0] lane_alarm,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [NUM_KINDS-1:0] out_active_alarms,
  output logic [NUM_KINDS-1:0] out_transmit_alarms
);

  logic [NUM_KINDS-1:0] active_r;
  logic [NUM_KINDS-1:0] active_nxt;
  logic [NUM_KINDS-1:0] sticky_r;
  logic [NUM_KINDS-1:0] sticky_nxt;
  logic [NUM_KINDS-1:0] tx;
  logic [NUM_KINDS-1:0] act_out_r;
  logic [NUM_KINDS-1:0] tx_out_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 kind_alarm;
  logic                 fire;

  assign kind_alarm = |lane_alarm;
  assign fire       = s2_tag.valid && (!out_valid_r || out_ready);

  always_comb begin
    active_nxt = active_r;
    sticky_nxt = sticky_r;
    tx         = sticky_r;
    unique case (s2_tag.cmd)
      CMD_PROBE, CMD_LOAD, CMD_SUPPLY, CMD_ENV: begin
        active_nxt[s2_tag.cmd[KIND_W-1:0]] = kind_alarm;
        sticky_nxt = sticky_r | active_nxt;
        tx         = sticky_nxt;
      end
      CMD_READ_CLR: begin
        sticky_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      sticky_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        active_r <= active_nxt;
        sticky_r <= sticky_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      act_out_r <= active_nxt;
      tx_out_r  <= tx;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_active_alarms   = act_out_r;
  assign out_transmit_alarms = tx_out_r;

endmodule

@@ rtl/core/sensor_threshold_alarm_monitor_unit.sv @@
// Top level of the sensor threshold alarm monitor.
// Each input item is one sample record (probes, load cells, supplies or
// environment) or a read of the sticky transmit bits, selected by in_cmd.
// Both channels use valid and ready; the configuration port takes a write
// of one limit register in every cycle that cfg_we is high.
// The block is a three-stage pipeline: the front stage forms lane operands
// from the record, the limits and the stored previous sample; four compare
// lanes check one value each; the merge stage updates the active and sticky
// bits and holds the result item.
// The item passes the front, lane and merge registers in turn before out_valid
// rises. Throughput: one item per cycle while the receiver takes results.
// When the receiver stalls, the result is held and the earlier stages keep
// filling; in_ready falls only once the output and both stages are full.
// Reset loads the default limits and clears the sample history and alarm
// bits; the block takes items from the first cycle after reset.
module sensor_threshold_alarm_monitor_unit
  import stam_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [CNT_W-1:0]      in_count_or_mask,
  input  logic signed [VAL_W-1:0] in_value_0,
  input  logic signed [VAL_W-1:0] in_value_1,
  input  logic signed [VAL_W-1:0] in_value_2,
  input  logic signed [VAL_W-1:0] in_value_3,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [NUM_KINDS-1:0]  out_active_alarms,
  output logic [NUM_KINDS-1:0]  out_transmit_alarms
);

  stage_tag_t           s1_tag;
  lane_cfg_t            s1_lane [NUM_LANES];
  logic                 v2_r;
  logic [CMD_W-1:0]     cmd2_r;
  stage_tag_t           s2_tag;
  logic [NUM_LANES-1:0] lane_alarm;
  logic                 adv_out;
  logic                 adv2;
  logic                 in_load;

  assign adv_out  = !out_valid || out_ready;
  assign adv2     = !v2_r || adv_out;
  assign in_ready = !s1_tag.valid || adv2;
  assign in_load  = in_valid && in_ready;

  stam_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_load          (in_load),
    .s1_adv           (adv2),
    .in_cmd           (in_cmd),
    .in_count_or_mask (in_count_or_mask),
    .in_value_0       (in_value_0),
    .in_value_1       (in_value_1),
    .in_value_2       (in_value_2),
    .in_value_3       (in_value_3),
    .s1_tag           (s1_tag),
    .s1_lane          (s1_lane)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    stam_lane u_lane (
      .clk     (clk),
      .en      (adv2),
      .cfg     (s1_lane[g]),
      .alarm_r (lane_alarm[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= s1_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      cmd2_r <= s1_tag.cmd;
    end
  end

  assign s2_tag.valid = v2_r;
  assign s2_tag.cmd   = cmd2_r;

  stam_merge u_merge (
    .clk                 (clk),
    .rst_n               (rst_n),
    .s2_tag              (s2_tag),
    .lane_alarm          (lane_alarm),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_active_alarms   (out_active_alarms),
    .out_transmit_alarms (out_transmit_alarms)
  );

endmodule

@@ rtl/core/stam_checker.sv @@
// Port-level checker of the alarm monitor and its bind to the top level.
`include "sensor_threshold_alarm_monitor_unit_defines.svh"

module stam_checker
  import stam_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [NUM_KINDS-1:0] out_active_alarms,
  input logic [NUM_KINDS-1:0] out_transmit_alarms
);

  `STAM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "Result item dropped while stalled.")
  `STAM_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_active_alarms) && $stable(out_transmit_alarms), "Stalled result item changed.")
  `STAM_ASSERT(a_stall_cause, !in_ready |-> out_valid && !out_ready, "Input stalled without a stalled result item.")
  `STAM_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && in_ready, "Block not idle after reset.")

endmodule

bind sensor_threshold_alarm_monitor_unit stam_checker u_stam_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_active_alarms   (out_active_alarms),
  .out_transmit_alarms (out_transmit_alarms)
);

@@ tb/sensor_threshold_alarm_monitor_unit_test.sv @@
// Self-checking testbench for the sensor threshold alarm monitor.
`timescale 1ns / 100ps

module sensor_threshold_alarm_monitor_unit_test;
  import stam_pkg::*;

  localparam int NUM_REGS = 7;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam int KIND_PROBE  = 0;
  localparam int KIND_LOAD   = 1;
  localparam int KIND_SUPPLY = 2;
  localparam int KIND_ENV    = 3;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [CNT_W-1:0]        com;
    logic [3:0][VAL_W-1:0]   val;
  } sample_item_t;

  typedef struct packed {
    logic [NUM_KINDS-1:0] active;
    logic [NUM_KINDS-1:0] transmit;
  } alarm_report_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [CMD_W-1:0]        in_cmd = '0;
  logic [CNT_W-1:0]        in_count_or_mask = '0;
  logic signed [VAL_W-1:0] in_value_0 = '0;
  logic signed [VAL_W-1:0] in_value_1 = '0;
  logic signed [VAL_W-1:0] in_value_2 = '0;
  logic signed [VAL_W-1:0] in_value_3 = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [NUM_KINDS-1:0]    out_active_alarms;
  logic [NUM_KINDS-1:0]    out_transmit_alarms;

  logic [63:0] limit_regs [NUM_REGS] = '{64'(RST_PROBE_LIM), RST_LOAD_LIM,
                                         64'(RST_LOAD_DIFF), 64'(RST_SUPPLY_LIM),
                                         64'(RST_ENV_T_LIM), 64'(RST_ENV_U_LIM),
                                         64'(RST_ENV_U_LIM)};
  logic [NUM_KINDS-1:0] alarm_active = '0;
  logic [NUM_KINDS-1:0] alarm_sticky = '0;
  logic [15:0] probe_last [PROBE_FIELDS] = '{default: '0};
  logic [2:0]  probe_last_count = '0;
  logic [31:0] load_last [LOAD_FIELDS] = '{default: '0};
  logic [2:0]  load_last_mask = '0;
  logic [15:0] supply_last [SUPPLY_FIELDS] = '{default: '0};
  logic [15:0] env_last [ENV_FIELDS] = '{default: '0};

  alarm_report_t pending_reports [$];
  int  mismatches = 0;
  bit  steady_flow = 1'b0;
  bit  stall_request = 1'b0;
  int  hold_left = 0;

  sensor_threshold_alarm_monitor_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_count_or_mask    (in_count_or_mask),
    .in_value_0          (in_value_0),
    .in_value_1          (in_value_1),
    .in_value_2          (in_value_2),
    .in_value_3          (in_value_3),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_active_alarms   (out_active_alarms),
    .out_transmit_alarms (out_transmit_alarms)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint abs_gap(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit u16_breach(logic [15:0] now, logic [15:0] prev, logic [47:0] lim,
                                    bit zero_diff_off);
    logic [15:0] lo, hi, step;
    longint jump;
    bit diff_on;
    lo = lim[15:0];
    hi = lim[31:16];
    step = lim[47:32];
    jump = (prev != 0) ? abs_gap(now, prev) : 0;
    diff_on = (step != U16_ALL_ONES) && !(zero_diff_off && step == 0);
    return (now < lo && lo != 0) || (now > hi && hi != U16_ALL_ONES) || (jump > step && diff_on);
  endfunction

  function automatic alarm_report_t predict_alarm_report(sample_item_t it);
    alarm_report_t rep;
    logic signed [15:0] smin, smax, s_now;
    logic [15:0] udiff;
    logic signed [31:0] lmin, lmax, l_now;
    logic [31:0] ldiff;
    longint jump;
    int n;
    bit hit;
    hit = 1'b0;
    case (it.cmd)
      CMD_PROBE: begin
        smin = limit_regs[REG_PROBE][15:0];
        smax = limit_regs[REG_PROBE][31:16];
        udiff = limit_regs[REG_PROBE][47:32];
        n = (it.com > PROBE_LIM) ? PROBE_LIM : int'(it.com);
        for (int i = 0; i < n; i++) begin
          s_now = it.val[i][15:0];
          jump = (i < probe_last_count) ? abs_gap(s_now, $signed(probe_last[i])) : 0;
          if ((s_now >= smax && smax != S16_TOP) || (s_now <= smin && smin != S16_BOTTOM) ||
              (jump > udiff && udiff != U16_ALL_ONES)) begin
            hit = 1'b1;
          end
        end
        alarm_active[KIND_PROBE] = hit;
        for (int i = 0; i < PROBE_FIELDS; i++) probe_last[i] = it.val[i][15:0];
        probe_last_count = 3'(n);
      end
      CMD_LOAD: begin
        lmin = limit_regs[REG_LOAD][31:0];
        lmax = limit_regs[REG_LOAD][63:32];
        ldiff = limit_regs[REG_LOAD_DIFF][31:0];
        for (int i = 0; i < LOAD_LIM; i++) begin
          if (it.com[i]) begin
            l_now = it.val[i];
            jump = load_last_mask[i] ? abs_gap(l_now, $signed(load_last[i])) : 0;
            if ((l_now >= lmax && lmax != S32_TOP) || (l_now <= lmin && lmin != S32_BOTTOM) ||
                (jump > ldiff && ldiff != U32_ALL_ONES)) begin
              hit = 1'b1;
            end
          end
        end
        alarm_active[KIND_LOAD] = hit;
        for (int i = 0; i < LOAD_FIELDS; i++) load_last[i] = it.val[i];
        load_last_mask = it.com;
      end
      CMD_SUPPLY: begin
        for (int i = 0; i < SUPPLY_FIELDS; i++) begin
          if (u16_breach(it.val[i][15:0], supply_last[i], limit_regs[REG_SUPPLY][47:0], 1'b0)) begin
            hit = 1'b1;
          end
        end
        alarm_active[KIND_SUPPLY] = hit;
        for (int i = 0; i < SUPPLY_FIELDS; i++) supply_last[i] = it.val[i][15:0];
      end
      CMD_ENV: begin
        smin = limit_regs[REG_ENV_TEMP][15:0];
        smax = limit_regs[REG_ENV_TEMP][31:16];
        udiff = limit_regs[REG_ENV_TEMP][47:32];
        s_now = it.val[0][15:0];
        jump = (env_last[0] != 0) ? abs_gap(s_now, $signed(env_last[0])) : 0;
        hit = (s_now < smin && smin != S16_BOTTOM) || (s_now > smax && smax != S16_TOP) ||
              (jump > udiff && udiff != U16_ALL_ONES && udiff != 0);
        if (u16_breach(it.val[1][15:0], env_last[1], limit_regs[REG_ENV_HUM][47:0], 1'b1) ||
            u16_breach(it.val[2][15:0], env_last[2], limit_regs[REG_ENV_PRES][47:0], 1'b1)) begin
          hit = 1'b1;
        end
        alarm_active[KIND_ENV] = hit;
        for (int i = 0; i < ENV_FIELDS; i++) env_last[i] = it.val[i][15:0];
      end
      default: ;
    endcase
    if (it.cmd <= CMD_ENV) alarm_sticky |= alarm_active;
    rep.active = alarm_active;
    rep.transmit = alarm_sticky;
    if (it.cmd == CMD_READ_CLR) alarm_sticky = '0;
    return rep;
  endfunction

  // Results are checked before the item accepted at the same edge is predicted.
  always @(posedge clk) begin
    alarm_report_t want;
    sample_item_t seen;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected alarm report: active %h, transmit %h",
                 out_active_alarms, out_transmit_alarms);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          if (out_active_alarms !== want.active) begin
            $error("active_alarms mismatch: expected %h, actual %h",
                   want.active, out_active_alarms);
            mismatches++;
          end
          if (out_transmit_alarms !== want.transmit) begin
            $error("transmit_alarms mismatch: expected %h, actual %h",
                   want.transmit, out_transmit_alarms);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        seen.cmd = in_cmd;
        seen.com = in_count_or_mask;
        seen.val[0] = in_value_0;
        seen.val[1] = in_value_1;
        seen.val[2] = in_value_2;
        seen.val[3] = in_value_3;
        pending_reports.push_back(predict_alarm_report(seen));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_request) begin
      stall_request = 1'b0;
      hold_left = 60;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady_flow || ($urandom_range(99) >= 33);
    end
  end

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic [31:0] pick_or(logic [31:0] sentinel, int lo, int hi);
    return ($urandom_range(4) == 0) ? sentinel : 32'(span(lo, hi));
  endfunction

  function automatic logic [47:0] rand_lim16(bit signed_kind);
    logic [15:0] lo, hi, step;
    step = ($urandom_range(9) == 0) ? 16'h0 : 16'(pick_or(32'(U16_ALL_ONES), 0, 3000));
    if (signed_kind) begin
      lo = 16'(pick_or(32'(S16_BOTTOM), -2500, 0));
      hi = 16'(pick_or(32'(S16_TOP), 0, 2500));
    end else begin
      lo = 16'(pick_or(32'h0, 0, 25000));
      hi = 16'(pick_or(32'(U16_ALL_ONES), 25000, 55000));
    end
    return {step, hi, lo};
  endfunction

  function automatic logic [31:0] rand_value(logic [CMD_W-1:0] cmd, int lane);
    int r;
    logic [15:0] upper;
    r = $urandom_range(99);
    upper = 16'($urandom);
    if (r < 8) return $urandom;
    if (r < 12) begin
      case ($urandom_range(3))
        0: return S32_TOP;
        1: return S32_BOTTOM;
        2: return {upper, S16_TOP};
        default: return {upper, S16_BOTTOM};
      endcase
    end
    if (r < 17) return {upper, 16'h0};
    if (cmd == CMD_LOAD) return 32'(span(-160000, 160000));
    if (cmd == CMD_PROBE || (cmd == CMD_ENV && lane == 0)) return {upper, 16'(span(-2800, 2800))};
    return {upper, 16'(span(0, 58000))};
  endfunction

  function automatic sample_item_t rand_sample();
    sample_item_t it;
    int r;
    r = $urandom_range(99);
    if (r < 22) it.cmd = CMD_PROBE;
    else if (r < 44) it.cmd = CMD_LOAD;
    else if (r < 64) it.cmd = CMD_SUPPLY;
    else if (r < 84) it.cmd = CMD_ENV;
    else if (r < 91) it.cmd = CMD_READ;
    else if (r < 97) it.cmd = CMD_READ_CLR;
    else if (r < 98) it.cmd = CMD_SPARE_6;
    else it.cmd = CMD_SPARE_7;
    it.com = 3'($urandom_range(7));
    for (int i = 0; i < 4; i++) it.val[i] = rand_value(it.cmd, i);
    return it;
  endfunction

  task automatic send_sample(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] com,
                             input logic [31:0] v0, input logic [31:0] v1,
                             input logic [31:0] v2, input logic [31:0] v3);
    int gap;
    gap = (!steady_flow && $urandom_range(99) < 20) ? span(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_count_or_mask <= com;
    in_value_0 <= v0;
    in_value_1 <= v1;
    in_value_2 <= v2;
    in_value_3 <= v3;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(int count);
    sample_item_t it;
    repeat (count) begin
      it = rand_sample();
      send_sample(it.cmd, it.com, it.val[0], it.val[1], it.val[2], it.val[3]);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_limits(input logic [63:0] words [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= words[i];
      limit_regs[i] = words[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_sample(CMD_PROBE, 3'd4, 32'h0000_7FFF, 32'hFFFF_8000, 32'h0, 32'hFFFF_FFFF);
    send_sample(CMD_LOAD, 3'd7, S32_TOP, S32_BOTTOM, 32'h0, 32'h1234_5678);
    send_sample(CMD_ENV, 3'd0, 32'h0000_8000, 32'h0000_FFFF, 32'h0001_0000, 32'h0);
    send_sample(CMD_SPARE_6, 3'd5, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(CMD_SPARE_7, 3'd2, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1, 32'h2);
    send_sample(CMD_READ_CLR, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_probe_checks();
    logic [63:0] words [NUM_REGS];
    drain();
    words = limit_regs;
    words[REG_PROBE] = {16'h0000, 16'd50, 16'd500, 16'(-100)};
    program_limits(words);
    send_sample(CMD_PROBE, 3'd0, 32'h7FFF_7FFF, 32'h8000, 32'h7FFF, 32'h0);
    send_sample(CMD_PROBE, 3'd2, 32'd500, 32'd0, 32'd0, 32'd0);
    send_sample(CMD_PROBE, 3'd7, 32'd460, 32'd20, 32'd300, 32'(-100));
    send_sample(CMD_PROBE, 3'd4, 32'hABCD_01CF, 32'd71, 32'd300, 32'(-60));
    send_sample(CMD_PROBE, 3'd4, 32'd470, 32'd80, 32'd320, 32'(-55));
  endtask

  task automatic test_load_checks();
    logic [63:0] words [NUM_REGS];
    drain();
    words = limit_regs;
    words[REG_LOAD] = {S32_TOP, S32_BOTTOM};
    words[REG_LOAD_DIFF] = {32'h0, 32'hFFFF_FFFE};
    program_limits(words);
    // The full-scale jump only exceeds the limit if the difference is exact.
    send_sample(CMD_LOAD, 3'b001, S32_BOTTOM, 32'h0, 32'h0, 32'h0);
    send_sample(CMD_LOAD, 3'b100, 32'h0, 32'h0, 32'(-5), 32'h0);
    send_sample(CMD_LOAD, 3'b000, S32_TOP, S32_BOTTOM, S32_TOP, 32'h0);
    drain();
    words[REG_LOAD] = {32'd1000, 32'(-1000)};
    words[REG_LOAD_DIFF] = {32'h0, 32'd100};
    program_limits(words);
    send_sample(CMD_LOAD, 3'b111, 32'd1000, 32'(-1000), 32'd3, 32'h0);
    send_sample(CMD_LOAD, 3'b110, 32'd5000, 32'(-999), 32'd50, 32'h0);
  endtask

  task automatic test_supply_env_checks();
    logic [63:0] words [NUM_REGS];
    drain();
    words = limit_regs;
    words[REG_SUPPLY] = {16'h0000, 16'd200, 16'd4200, 16'd3000};
    words[REG_ENV_TEMP] = {16'h0000, 16'd0, 16'd3000, 16'(-1000)};
    words[REG_ENV_HUM] = {16'h0000, 16'd0, 16'd9000, 16'd1000};
    words[REG_ENV_PRES] = {16'h0000, 16'd500, 16'd60000, 16'd30000};
    program_limits(words);
    send_sample(CMD_SUPPLY, 3'd0, 32'd3000, 32'd4200, 32'h0, 32'h0);
    send_sample(CMD_SUPPLY, 3'd0, 32'd2999, 32'd4000, 32'h0, 32'h0);
    send_sample(CMD_SUPPLY, 3'd0, 32'd3100, 32'd4201, 32'h0, 32'h0);
    send_sample(CMD_ENV, 3'd0, 32'd3000, 32'd1000, 32'd30000, 32'h0);
    send_sample(CMD_ENV, 3'd0, 32'd3001, 32'd1000, 32'd30000, 32'h0);
    send_sample(CMD_ENV, 3'd0, 32'(-1000), 32'd9000, 32'd30501, 32'h0);
  endtask

  task automatic test_sticky_read_clear();
    send_sample(CMD_READ, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_sample(CMD_READ_CLR, 3'd7, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    send_sample(CMD_READ, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_input_stall();
    drain();
    steady_flow = 1'b1;
    stall_request = 1'b1;
    send_random(16);
    steady_flow = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [63:0] words [NUM_REGS];
    for (int p = 0; p < 10; p++) begin
      drain();
      case (p)
        0: foreach (words[i]) words[i] = '0;
        1: foreach (words[i]) words[i] = '1;
        2: words = '{64'(RST_PROBE_LIM), RST_LOAD_LIM, 64'(RST_LOAD_DIFF),
                     64'(RST_SUPPLY_LIM), 64'(RST_ENV_T_LIM), 64'(RST_ENV_U_LIM),
                     64'(RST_ENV_U_LIM)};
        default: begin
          words[REG_PROBE] = {16'($urandom), rand_lim16(1'b1)};
          words[REG_LOAD] = {pick_or(S32_TOP, 0, 150000), pick_or(S32_BOTTOM, -150000, 0)};
          words[REG_LOAD_DIFF] = {32'($urandom),
                                  ($urandom_range(9) == 0) ? 32'($urandom)
                                                           : pick_or(U32_ALL_ONES, 0, 60000)};
          words[REG_SUPPLY] = {16'($urandom), rand_lim16(1'b0)};
          words[REG_ENV_TEMP] = {16'($urandom), rand_lim16(1'b1)};
          words[REG_ENV_HUM] = {16'($urandom), rand_lim16(1'b0)};
          words[REG_ENV_PRES] = {16'($urandom), rand_lim16(1'b0)};
        end
      endcase
      program_limits(words);
      steady_flow = (p == 4);
      send_random(50);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_probe_checks();
    test_load_checks();
    test_supply_env_checks();
    test_sticky_read_clear();
    test_input_stall();
    test_random_traffic();
    in_valid <= 1'b0;
    repeat (4000) begin
      @(posedge clk);
      if (pending_reports.size() == 0) break;
    end
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d alarm reports never arrived", pending_reports.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
